// ----- hdl/bgnt_pkg.sv -----
`default_nettype none
package bgnt_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // config register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_GEN
  } bgnt_state_t;

  // vertical window of one column: rows r-1, r, r+1
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } bgnt_col_t;

  // window control shared by every cell
  typedef struct packed {
    logic clr;
    logic shift;
  } bgnt_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/bgnt_ram.sv -----
`default_nettype none
module bgnt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/bgnt_cell.sv -----
`default_nettype none
module bgnt_cell #(
  parameter int THRESH = 3
) (
  input  logic                 clk,
  input  bgnt_pkg::bgnt_ctl_t  ctl,
  input  logic                 en,
  input  logic                 din,
  input  bgnt_pkg::bgnt_col_t  left_col,
  input  bgnt_pkg::bgnt_col_t  right_col,
  output bgnt_pkg::bgnt_col_t  own_col,
  output logic                 nxt_bit
);
  import bgnt_pkg::*;

  logic up_r, mid_r, dn_r;
  logic [3:0] cnt;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      up_r  <= 1'b0;
      mid_r <= 1'b0;
      dn_r  <= 1'b0;
    end else if (ctl.shift) begin
      up_r  <= mid_r;
      mid_r <= dn_r;
      dn_r  <= din;
    end
  end

  // columns past the active width look empty to their neighbors
  assign own_col = en ? bgnt_col_t'{up: up_r, mid: mid_r, dn: dn_r} : '0;

  assign cnt = 4'(left_col.up) + 4'(left_col.mid) + 4'(left_col.dn)
             + 4'(right_col.up) + 4'(right_col.mid) + 4'(right_col.dn)
             + 4'(up_r) + 4'(dn_r);

  // inactive columns keep their stored bit
  assign nxt_bit = en ? (cnt >= 4'(THRESH)) : mid_r;

endmodule
`default_nettype wire

// ----- hdl/binary_grid_neighbor_threshold_step.sv -----
`default_nettype none
// Binary cell grid with a threshold neighbor rule. Commands are taken when
// start is high and busy is low; every command yields exactly one result
// beat on out_valid, one cycle wide, which the receiver cannot stall.
// Timing: an out-of-range access or an unknown command returns its beat the
// cycle after it is taken. An in-range read or write first reads its row
// through the grid RAM read port (read-modify-write for a write) and
// registers its beat from the ACCESS state. A generation sweeps the active
// rows through a three-row window held in a row of MAX_COLS cells, reading
// a row from the RAM per cycle and writing one back once the window is full.
// After reset the grid RAM is cleared one row per cycle, all MAX_ROWS rows;
// busy stays high meanwhile, config writes are taken as usual.
// Config registers: grid_rows at address 0, grid_cols at 4 (7 bits each).
module binary_grid_neighbor_threshold_step #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int BIRTH_THRESHOLD = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic        in_write_value,
  // result channel
  output logic        out_valid,
  output logic        out_read_value,
  output logic        out_out_of_range,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bgnt_pkg::*;

  // row address, column index, row-count and column-count widths
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW  = ($clog2(MAX_ROWS + 2) > 7) ? $clog2(MAX_ROWS + 2) : 7;
  localparam int CCW = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;

  // ---------------- config registers ----------------
  logic [6:0] grid_rows_r, grid_cols_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= 7'd64;
      grid_cols_r <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        grid_rows_r <= pwdata[6:0];
      end else begin
        grid_cols_r <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? {25'd0, grid_rows_r} : {25'd0, grid_cols_r};

  // effective size: zero acts as one, oversize clamps to the maximum
  logic [CW-1:0]  eff_rows;
  logic [CCW-1:0] eff_cols;

  always_comb begin
    if (grid_rows_r == 7'd0) begin
      eff_rows = CW'(1);
    end else if (CW'(grid_rows_r) > CW'(MAX_ROWS)) begin
      eff_rows = CW'(MAX_ROWS);
    end else begin
      eff_rows = CW'(grid_rows_r);
    end
    if (grid_cols_r == 7'd0) begin
      eff_cols = CCW'(1);
    end else if (CCW'(grid_cols_r) > CCW'(MAX_COLS)) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(grid_cols_r);
    end
  end

  // ---------------- grid RAM: one row per word ----------------
  logic                ram_we;
  logic [RAW-1:0]      ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  bgnt_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- row of cells ----------------
  bgnt_ctl_t           cell_ctl;
  logic [MAX_COLS-1:0] col_en;
  logic [MAX_COLS-1:0] din_row;
  logic [MAX_COLS-1:0] new_row;
  bgnt_col_t           col_own [MAX_COLS];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    bgnt_col_t left_c, right_c;

    if (c == 0) begin : g_left_edge
      assign left_c = '0;
    end else begin : g_left
      assign left_c = col_own[c-1];
    end
    if (c == MAX_COLS - 1) begin : g_right_edge
      assign right_c = '0;
    end else begin : g_right
      assign right_c = col_own[c+1];
    end

    assign col_en[c] = (CCW'(c) < eff_cols);

    bgnt_cell #(
      .THRESH (BIRTH_THRESHOLD)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .en        (col_en[c]),
      .din       (din_row[c]),
      .left_col  (left_c),
      .right_col (right_c),
      .own_col   (col_own[c]),
      .nxt_bit   (new_row[c])
    );
  end

  // ---------------- control ----------------
  bgnt_state_t    state_r, state_nxt;
  logic [RAW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]  k_r, k_nxt;            // rows shifted into the window so far
  logic [RAW-1:0] row_r, row_nxt;
  logic [CAW-1:0] col_r, col_nxt;
  logic           is_wr_r, is_wr_nxt;
  logic           wval_r, wval_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_rd_r, out_rd_nxt;
  logic           out_oor_r, out_oor_nxt;

  logic           accept;
  logic           row_ok, col_ok;
  logic [CW-1:0]  k_p1, k_m2;
  logic [MAX_COLS-1:0] row_mod;

  assign accept = start && (state_r == ST_IDLE);
  assign row_ok = CW'(in_row_index) < eff_rows;
  assign col_ok = CCW'(in_col_index) < eff_cols;
  assign k_p1   = k_r + CW'(1);
  assign k_m2   = k_r - CW'(2);

  // rows past the active height enter the window as zeros
  assign din_row = (k_r < eff_rows) ? ram_rdata : '0;

  always_comb begin
    row_mod        = ram_rdata;
    row_mod[col_r] = wval_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    is_wr_nxt     = is_wr_r;
    wval_nxt      = wval_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = 1'b0;
    out_oor_nxt   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    cell_ctl      = '{clr: 1'b0, shift: 1'b0};

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + RAW'(1);
        if (clr_cnt_r == RAW'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          row_nxt   = RAW'(CW'(in_row_index));
          col_nxt   = CAW'(CCW'(in_col_index));
          is_wr_nxt = (in_command == CMD_WRITE);
          wval_nxt  = in_write_value;
          case (in_command)
            CMD_WRITE, CMD_READ: begin
              if (row_ok && col_ok) begin
                ram_raddr = RAW'(CW'(in_row_index));
                state_nxt = ST_ACCESS;
              end else begin
                out_valid_nxt = 1'b1;
                out_oor_nxt   = 1'b1;
              end
            end
            CMD_STEP: begin
              ram_raddr    = '0;
              k_nxt        = '0;
              cell_ctl.clr = 1'b1;
              state_nxt    = ST_GEN;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        out_valid_nxt = 1'b1;
        if (is_wr_r) begin
          ram_we    = 1'b1;
          ram_waddr = row_r;
          ram_wdata = row_mod;
        end else begin
          out_rd_nxt = ram_rdata[col_r];
        end
        state_nxt = ST_IDLE;
      end

      ST_GEN: begin
        // window holds rows k-3..k-1; its center row k-2 is written back
        cell_ctl.shift = 1'b1;
        ram_raddr      = k_p1[RAW-1:0];
        k_nxt          = k_p1;
        if (k_r >= CW'(2)) begin
          ram_we    = 1'b1;
          ram_waddr = k_m2[RAW-1:0];
          ram_wdata = new_row;
        end
        if (k_r == eff_rows + CW'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    is_wr_r   <= is_wr_nxt;
    wval_r    <= wval_nxt;
    out_rd_r  <= out_rd_nxt;
    out_oor_r <= out_oor_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_rd_r;
  assign out_out_of_range = out_oor_r;

endmodule
`default_nettype wire

// ----- tb/binary_grid_neighbor_threshold_step_tb.sv -----
`timescale 1ns / 1ps

module binary_grid_neighbor_threshold_step_tb;
  import bgnt_pkg::*;

  localparam int GRID_DIM     = 64;                  // fixed row stride and max size
  localparam int MAX_CELLS    = GRID_DIM * GRID_DIM;
  localparam int BIRTH_COUNT  = 3;                   // neighbors needed for a live cell
  localparam logic [1:0] CMD_NOP = 2'd3;             // undefined code, grid left unchanged
  localparam int RANDOM_ITEMS = 110;
  localparam int QUIET_TAIL   = 20;                  // last beats sent with no gaps
  localparam int DRAIN_CYCLES = 100;                 // longer than a generation on the largest grid
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic read_value;
    logic out_of_range;
  } cell_result_t;

  // Grid predictor plus the queue of results still owed by the block.
  class grid_scoreboard;
    bit           cells [MAX_CELLS];
    bit [6:0]     rows_reg;
    bit [6:0]     cols_reg;
    cell_result_t pending_results [$];
    int           errors;
    int           checked;
    int           generations;

    function new();
      foreach (cells[i]) cells[i] = 1'b0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
    endfunction

    // register value as the block uses it: 0 acts as 1, above max acts as max
    function int clamp_size(bit [6:0] v);
      if (v == 7'd0) return 1;
      if (v > GRID_DIM) return GRID_DIM;
      return int'(v);
    endfunction

    function int active_rows();
      return clamp_size(rows_reg);
    endfunction

    function int active_cols();
      return clamp_size(cols_reg);
    endfunction

    function void set_register(logic idx, bit [6:0] v);
      if (idx == REG_ROWS) rows_reg = v;
      else cols_reg = v;
    endfunction

    // neighbor lookup; anything off the active grid counts as dead
    function int live(int r, int c);
      if (r < 0 || c < 0 || r >= active_rows() || c >= active_cols()) return 0;
      return int'(cells[r * GRID_DIM + c]);
    endfunction

    function void advance_generation();
      bit nxt [MAX_CELLS];
      int rows;
      int cols;
      int cnt;
      rows = active_rows();
      cols = active_cols();
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          cnt = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if (dr != 0 || dc != 0) cnt += live(r + dr, c + dc);
          nxt[r * GRID_DIM + c] = (cnt >= BIRTH_COUNT);
        end
      end
      // commit all at once; cells outside the active grid are untouched
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++)
          cells[r * GRID_DIM + c] = nxt[r * GRID_DIM + c];
      generations++;
    endfunction

    function void note_command(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                               logic wv);
      cell_result_t want;
      int idx;
      want = '0;
      idx  = int'(row) * GRID_DIM + int'(col);
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
        if (int'(row) >= active_rows() || int'(col) >= active_cols())
          want.out_of_range = 1'b1;
        else if (cmd == CMD_WRITE)
          cells[idx] = wv;
        else
          want.read_value = cells[idx];
      end else if (cmd == CMD_STEP) begin
        advance_generation();
      end
      pending_results.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic rd, logic oor);
      cell_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing pending (rd=%b oor=%b)", rd, oor));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (rd !== want.read_value)
        report($sformatf("read_value got %b want %b", rd, want.read_value));
      if (oor !== want.out_of_range)
        report($sformatf("out_of_range got %b want %b", oor, want.out_of_range));
    endtask
  endclass

  // DUT signals; everything driven from time zero
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  in_command     = CMD_WRITE;
  logic [5:0]  in_row_index   = '0;
  logic [5:0]  in_col_index   = '0;
  logic        in_write_value = 1'b0;
  logic        out_valid;
  logic        out_read_value;
  logic        out_out_of_range;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_scoreboard sb;
  int items_sent;
  int cfg_writes;
  int cycle_count;
  bit quiet;          // suppress sender gaps

  binary_grid_neighbor_threshold_step #(
    .MAX_ROWS       (GRID_DIM),
    .MAX_COLS       (GRID_DIM),
    .BIRTH_THRESHOLD(BIRTH_COUNT)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_out_of_range(out_out_of_range),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Monitor. A result beat at this edge always belongs to an earlier command,
  // so check it before noting a command taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        sb.check_result(out_read_value, out_out_of_range);
      if (start === 1'b1 && busy === 1'b0)
        sb.note_command(in_command, in_row_index, in_col_index, in_write_value);
    end
  end

  // Sender idle: start low, payload scrambled so it is clearly ignored.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start          <= 1'b0;
      in_command     <= 2'($urandom);
      in_row_index   <= 6'($urandom);
      in_col_index   <= 6'($urandom);
      in_write_value <= 1'($urandom);
    end
  endtask

  // One command beat; start stays high if the caller sends again right away.
  task automatic send_command(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                              logic wv);
    @(negedge clk);
    start          <= 1'b1;
    in_command     <= cmd;
    in_row_index   <= row;
    in_col_index   <= col;
    in_write_value <= wv;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 10));
  endtask

  // Hold the sender until every owed result has come and the block is idle.
  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup, then access; register lands at the access edge.
  task automatic cfg_write(logic idx, bit [6:0] value, bit junk_upper);
    logic [31:0] data;
    data      = junk_upper ? $urandom : 32'd0;
    data[6:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_register(idx, value);
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly small grids so patterns get dense, with the extremes mixed in.
  function automatic bit [6:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'($urandom_range(65, 127));
      3:       return 7'd1;
      default: return 7'($urandom_range(2, 10));
    endcase
  endfunction

  function automatic logic [5:0] near(int base, int lim);
    int v;
    v = base + $urandom_range(0, 2);
    if (v >= lim) v = lim - 1;
    return 6'(v);
  endfunction

  initial begin
    int rows;
    int cols;
    int base_r;
    int base_c;
    int phase_end;
    int rnd_start;
    bit quiet_phase;
    logic [5:0] r;
    logic [5:0] c;

    sb = new();
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the block clears its grid after reset; busy covers that
    do @(posedge clk); while (busy !== 1'b0);

    // ---- directed: default 64x64 grid ----
    send_command(CMD_READ,  6'd0,  6'd0,  1'b0);  // cleared at reset
    send_command(CMD_READ,  6'd63, 6'd63, 1'b0);  // far corner
    send_command(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    send_command(CMD_WRITE, 6'd0,  6'd0,  1'b1);
    send_command(CMD_WRITE, 6'd0,  6'd1,  1'b1);
    send_command(CMD_WRITE, 6'd1,  6'd0,  1'b1);  // (1,1) now has 3 live neighbors
    send_command(CMD_READ,  6'd63, 6'd63, 1'b0);
    send_command(CMD_STEP,  6'd63, 6'd63, 1'b1);  // address fields ignored on a step
    send_command(CMD_READ,  6'd1,  6'd1,  1'b0);  // born
    send_command(CMD_READ,  6'd0,  6'd0,  1'b0);  // only 2 neighbors
    send_command(CMD_NOP,   6'd63, 6'd63, 1'b1);  // unknown code, no effect
    send_command(CMD_WRITE, 6'd1,  6'd1,  1'b0);
    send_command(CMD_WRITE, 6'd40, 6'd40, 1'b1);  // sits outside the next grids
    drain_results();

    // ---- directed: rows 0 acts as 1, cols 127 acts as 64 ----
    cfg_write(REG_ROWS, 7'd0,   1'b1);
    cfg_write(REG_COLS, 7'd127, 1'b0);
    send_command(CMD_WRITE, 6'd0, 6'd10, 1'b1);
    send_command(CMD_WRITE, 6'd0, 6'd11, 1'b1);
    send_command(CMD_WRITE, 6'd0, 6'd12, 1'b1);
    send_command(CMD_WRITE, 6'd1, 6'd0,  1'b1);   // row outside the grid
    send_command(CMD_READ,  6'd5, 6'd5,  1'b0);   // outside too
    send_command(CMD_STEP,  6'd0, 6'd0,  1'b0);   // one row: at most 2 neighbors
    send_command(CMD_READ,  6'd0, 6'd11, 1'b0);
    drain_results();

    // ---- directed: 64 rows, one column ----
    cfg_write(REG_ROWS, 7'd64, 1'b0);
    cfg_write(REG_COLS, 7'd1,  1'b1);
    send_command(CMD_READ,  6'd40, 6'd40, 1'b0);  // column outside the grid
    send_command(CMD_WRITE, 6'd63, 6'd0,  1'b1);
    send_command(CMD_STEP,  6'd0,  6'd0,  1'b0);
    send_command(CMD_READ,  6'd63, 6'd0,  1'b0);
    drain_results();

    // back to full size: cell kept through the small-grid generations
    cfg_write(REG_COLS, 7'd64, 1'b0);
    send_command(CMD_READ, 6'd40, 6'd40, 1'b0);

    // ---- random phases, each under a fresh grid size ----
    // once the quiet tail starts, the current phase runs on to the end
    rnd_start = items_sent;
    while (items_sent - rnd_start < RANDOM_ITEMS) begin
      drain_results();
      cfg_write(REG_ROWS, pick_size(), 1'($urandom));
      cfg_write(REG_COLS, pick_size(), 1'($urandom));
      rows        = sb.active_rows();
      cols        = sb.active_cols();
      phase_end   = items_sent + $urandom_range(18, 30);
      quiet_phase = ($urandom_range(0, 3) == 0);

      while ((items_sent < phase_end ||
              items_sent - rnd_start >= RANDOM_ITEMS - QUIET_TAIL) &&
             items_sent - rnd_start < RANDOM_ITEMS) begin
        quiet = quiet_phase || (items_sent - rnd_start >= RANDOM_ITEMS - QUIET_TAIL);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // clustered writes, one or two generations, reads of the cluster
            base_r = $urandom_range(0, rows - 1);
            base_c = $urandom_range(0, cols - 1);
            repeat ($urandom_range(3, 8))
              send_command(CMD_WRITE, near(base_r, rows), near(base_c, cols),
                           $urandom_range(0, 9) < 7);
            repeat ($urandom_range(1, 2))
              send_command(CMD_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
            repeat ($urandom_range(2, 5))
              send_command(CMD_READ, near(base_r, rows), near(base_c, cols),
                           1'($urandom));
          end
          6, 7: begin
            send_command(2'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
          end
          8: begin
            // aim past the active edge when there is one
            r = 6'($urandom);
            c = 6'($urandom);
            if (rows < GRID_DIM) r = 6'($urandom_range(rows, GRID_DIM - 1));
            else if (cols < GRID_DIM) c = 6'($urandom_range(cols, GRID_DIM - 1));
            send_command(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ, r, c,
                         1'($urandom));
          end
          default: begin
            // a generation, with the sender held until everything is back unless quiet
            send_command(CMD_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
            if (!quiet) drain_results();
          end
        endcase
      end
    end

    // ---- wind down ----
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d command beats, %0d generations, %0d results checked",
             items_sent, sb.generations, sb.checked);
    $display("tb: %0d size register writes, grids from 1 cell wide up to 64x64",
             cfg_writes);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
